// File: sv/i2c_rts_pkg.sv
package i2c_rts_pkg;

    localparam int PACKET_BYTES = 32;
    localparam int LEN_W        = $clog2(PACKET_BYTES + 1);
    localparam int ADDR_W       = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam int BYTE_W       = 8;
    localparam int TARGET_W     = 7;
    localparam int LIMIT_W      = 8;
    localparam int CFG_W        = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int BITS_W       = 4;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 7'd105;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd5;
    localparam logic [BITS_W-1:0]   BITS_START   = 4'd9;

    // input opcodes
    localparam logic [1:0] OP_SCL  = 2'd0;
    localparam logic [1:0] OP_SDA  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT     = 1'd1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ADDR,
        PH_DATA,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_COUNT,
        EM_READ,
        EM_DATA
    } emit_state_t;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
    } emit_req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } store_wr_t;

endpackage

// File: sv/i2c_read_transfer_sniffer.sv
// Passive monitor of I2C read transfers to one slave address. Each input transfer
// is one SCL edge, SDA edge or millisecond tick; edges and ticks are accepted
// whenever in_stall is low. When a stop follows a captured read (SCL rise with
// SDA low in the stop phase), the block emits the byte count and then the
// stored bytes, last one flagged. Emission walks the packet store, a RAM with
// a single registered read port: the count is loaded in EM_COUNT and each byte
// passes EM_READ (address) then EM_DATA (data); in_stall stays high after the
// stop until all n bytes (n up to 32) are loaded; out_stall can extend this. A
// finished result may sit in the output register while further edges and ticks
// are accepted. Configuration writes: index 0 target_address (reset 105), index 1
// idle_limit (reset 5); write only while no emission is in progress.
module i2c_read_transfer_sniffer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [i2c_rts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [i2c_rts_pkg::CFG_W-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          opcode,
    input  logic                                rising,
    input  logic                                scl_level,
    input  logic                                sda_level,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [i2c_rts_pkg::BYTE_W-1:0]      out_byte,
    output logic                                last
);

    import i2c_rts_pkg::*;

    logic              accept;
    logic              busy;
    store_wr_t         store_wr;
    emit_req_t         emit_req;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    assign in_stall = busy;
    assign accept   = in_valid && !in_stall;

    i2c_rts_rx u_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .opcode    (opcode),
        .rising    (rising),
        .scl_level (scl_level),
        .sda_level (sda_level),
        .store_wr  (store_wr),
        .emit_req  (emit_req)
    );

    i2c_rts_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PACKET_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr.en),
        .wr_addr (store_wr.addr),
        .wr_data (store_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    i2c_rts_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit_req  (emit_req),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

// File: sv/i2c_rts_ram.sv
module i2c_rts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/i2c_rts_rx.sv
module i2c_rts_rx (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [i2c_rts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2c_rts_pkg::CFG_W-1:0]        cfg_data,
    input  logic                                 accept,
    input  logic [1:0]                           opcode,
    input  logic                                 rising,
    input  logic                                 scl_level,
    input  logic                                 sda_level,
    output i2c_rts_pkg::store_wr_t               store_wr,
    output i2c_rts_pkg::emit_req_t               emit_req
);

    import i2c_rts_pkg::*;

    logic [TARGET_W-1:0] target_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    phase_t              phase_reg, phase_next;
    logic [BITS_W-1:0]   bits_reg, bits_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LIMIT_W-1:0]  ticks_reg, ticks_next;

    logic [BITS_W-1:0]   bits_dec;
    logic [BYTE_W-1:0]   addr_or;
    logic [BYTE_W-1:0]   data_or;
    logic [LIMIT_W-1:0]  ticks_inc;
    logic                drop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_ADDRESS: target_reg <= cfg_data[TARGET_W-1:0];
                CFG_IDLE_LIMIT:     limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bits_reg  <= BITS_START;
            shift_reg <= '0;
            len_reg   <= '0;
            ticks_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            len_reg   <= len_next;
            ticks_reg <= ticks_next;
        end
    end

    assign bits_dec  = bits_reg - 4'd1;
    // address bits land at 6..0, data bits at 7..0
    assign addr_or   = (bits_reg >= 4'd3 && bits_reg <= 4'd9)
                     ? (shift_reg | (BYTE_W'(sda_level) << (bits_reg - 4'd3))) : shift_reg;
    assign data_or   = (bits_reg >= 4'd2 && bits_reg <= 4'd9)
                     ? (shift_reg | (BYTE_W'(sda_level) << (bits_reg - 4'd2))) : shift_reg;
    assign ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + LIMIT_W'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        bits_next     = bits_reg;
        shift_next    = shift_reg;
        len_next      = len_reg;
        ticks_next    = ticks_reg;
        drop          = 1'b0;
        store_wr.en   = 1'b0;
        store_wr.addr = len_reg[ADDR_W-1:0];
        store_wr.data = data_or;
        emit_req.valid = 1'b0;
        emit_req.len   = len_reg;

        if (accept)
        begin
            case (opcode)
                OP_TICK:
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc > limit_reg && phase_reg != PH_IDLE)
                    begin
                        drop = 1'b1;
                    end
                end
                OP_SCL, OP_SDA:
                begin
                    ticks_next = '0;
                    if (phase_reg == PH_IDLE)
                    begin
                        if (opcode == OP_SDA && !rising)
                        begin
                            if (scl_level)
                            begin
                                phase_next = PH_ADDR;
                            end
                            else
                            begin
                                drop = 1'b1;
                            end
                        end
                    end
                    else if (opcode == OP_SCL && rising)
                    begin
                        case (phase_reg)
                            PH_ADDR:
                            begin
                                shift_next = addr_or;
                                bits_next  = bits_dec;
                                if (bits_reg == '0)
                                begin
                                    drop = 1'b1;
                                end
                                else if (bits_dec == 4'd2)
                                begin
                                    if (addr_or != {1'b0, target_reg})
                                    begin
                                        drop = 1'b1;
                                    end
                                end
                                else if (bits_dec == 4'd1)
                                begin
                                    // R/W must be read
                                    if (!sda_level)
                                    begin
                                        drop = 1'b1;
                                    end
                                end
                                else if (bits_dec == 4'd0)
                                begin
                                    if (!sda_level)
                                    begin
                                        shift_next = '0;
                                        bits_next  = BITS_START;
                                        phase_next = PH_DATA;
                                    end
                                    else
                                    begin
                                        drop = 1'b1;
                                    end
                                end
                            end
                            PH_DATA:
                            begin
                                shift_next = data_or;
                                bits_next  = bits_dec;
                                if (bits_reg == '0)
                                begin
                                    drop = 1'b1;
                                end
                                else if (bits_dec == 4'd1)
                                begin
                                    if (len_reg < LEN_W'(PACKET_BYTES))
                                    begin
                                        store_wr.en = 1'b1;
                                        len_next    = len_reg + LEN_W'(1);
                                    end
                                end
                                else if (bits_dec == 4'd0)
                                begin
                                    // NACK ends the data
                                    if (sda_level)
                                    begin
                                        phase_next = PH_STOP;
                                    end
                                    else
                                    begin
                                        shift_next = '0;
                                        bits_next  = BITS_START;
                                    end
                                end
                            end
                            PH_STOP:
                            begin
                                emit_req.valid = !sda_level;
                                drop           = 1'b1;
                            end
                            default:
                            begin
                                drop = 1'b1;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (drop)
        begin
            phase_next = PH_IDLE;
            bits_next  = BITS_START;
            shift_next = '0;
            len_next   = '0;
        end
    end

endmodule

// File: sv/i2c_rts_emit.sv
module i2c_rts_emit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  i2c_rts_pkg::emit_req_t              emit_req,
    output logic                                busy,
    output logic                                rd_en,
    output logic [i2c_rts_pkg::ADDR_W-1:0]      rd_addr,
    input  logic [i2c_rts_pkg::BYTE_W-1:0]      rd_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [i2c_rts_pkg::BYTE_W-1:0]      out_byte,
    output logic                                last
);

    import i2c_rts_pkg::*;

    emit_state_t         state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                last_reg, last_next;

    logic                out_free;
    logic                load;
    logic [LEN_W-1:0]    idx_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EM_IDLE;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign idx_inc  = idx_reg + LEN_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        out_byte_next = out_byte_reg;
        last_next     = last_reg;
        load          = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[ADDR_W-1:0];

        case (state_reg)
            EM_IDLE:
            begin
                if (emit_req.valid)
                begin
                    len_next   = emit_req.len;
                    idx_next   = '0;
                    state_next = EM_COUNT;
                end
            end
            EM_COUNT:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    out_byte_next = BYTE_W'(len_reg);
                    last_next     = (len_reg == '0);
                    state_next    = (len_reg == '0) ? EM_IDLE : EM_READ;
                end
            end
            EM_READ:
            begin
                rd_en      = 1'b1;
                state_next = EM_DATA;
            end
            EM_DATA:
            begin
                // read data stays put until the next read
                if (out_free)
                begin
                    load          = 1'b1;
                    out_byte_next = rd_data;
                    last_next     = (idx_inc == len_reg);
                    idx_next      = idx_inc;
                    state_next    = (idx_inc == len_reg) ? EM_IDLE : EM_READ;
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase

        out_valid_next = load | (out_valid_reg & out_stall);
    end

    assign busy      = (state_reg != EM_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

// File: sv/i2c_rts_checker.sv
module i2c_rts_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [1:0]                          opcode,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [i2c_rts_pkg::BYTE_W-1:0]      out_byte,
    input  logic                                last
);

    import i2c_rts_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled result changed");

    // a tick never starts an emission
    a_tick_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_TICK |=> !in_stall)
        else $error("tick stalled the input");

    // unused opcode never starts an emission
    a_rsvd_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_RSVD |=> !in_stall)
        else $error("unused opcode stalled the input");

    // coming out of reset nothing is pending
    a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("output or stall active after reset");

endmodule

bind i2c_read_transfer_sniffer i2c_rts_checker u_checker (.*);
